FILE: hw/rtl/ppmd_pkg.sv
`default_nettype none
package ppmd_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // final status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_MAGIC  = 3'd1;
  localparam logic [2:0] ST_HEADER = 3'd2;
  localparam logic [2:0] ST_P3     = 3'd3;
  localparam logic [2:0] ST_P6     = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0b;
  localparam logic [7:0] CH_FF   = 8'h0c;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SP   = 8'h20;

  localparam logic [7:0] SAMPLE_MAX = 8'd255;

  // queue entry kinds between parser and scaler
  typedef enum logic [1:0] {
    ENT_SAMPLE,
    ENT_HEADER,
    ENT_STATUS
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t   etype;
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  sample;
    logic [1:0]  chan;
    logic [7:0]  maxv;
    logic        last;
  } entry_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ppmd_queue.sv
`default_nettype none
module ppmd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ppmd_pkg::entry_t push_data,
  input  wire logic            pop,
  output ppmd_pkg::entry_t     head,
  output logic                 full,
  output logic                 empty
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  ppmd_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ppmd_front.sv
`default_nettype none
module ppmd_front #(
  parameter int DIM_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_valid,
  output logic                  byte_stall,
  input  wire logic [7:0]       data_byte,
  input  wire logic             end_of_file,
  output logic                  push,
  output ppmd_pkg::entry_t      push_data,
  input  wire logic             q_full
);

  localparam int TW = DIM_BITS + 1;
  localparam logic [TW-1:0] CAP = TW'(1) << DIM_BITS;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_P3DATA, PH_P6SKIP, PH_P6DATA, PH_FINISHED
  } phase_t;

  phase_t              phase, phase_next;
  logic                in_comment, in_comment_next;
  logic [TW-1:0]       tv, tv_next;
  logic [2:0]          tl, tl_next;
  logic                tb, tb_next;
  logic                bf, bf_next;
  logic [DIM_BITS-1:0] sw, sw_next;
  logic [DIM_BITS-1:0] sh, sh_next;
  logic [7:0]          ms, ms_next;
  logic [DIM_BITS-1:0] col, col_next;
  logic [DIM_BITS-1:0] row, row_next;
  logic [1:0]          ch, ch_next;
  logic                pend_valid;
  ppmd_pkg::entry_t    pend;
  ppmd_pkg::entry_t    ents [2];
  logic [1:0]          n;
  logic                accept;
  logic [DIM_BITS+15:0] wext;
  logic [DIM_BITS+15:0] hext;
  logic [TW+3:0]       acc;

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = pend_valid || q_full;
  assign wext       = {16'b0, sw};
  assign hext       = {16'b0, sh};
  assign acc        = {tv, 3'b0} + {2'b0, tv, 1'b0} + (TW+4)'(data_byte - ppmd_pkg::CH_0);

  // byte parser: dispatch, token close, sample, end of file
  always_comb begin
    logic             fin;
    logic             samp;
    logic [7:0]       sv;
    logic [TW-1:0]    v;
    logic             bad;
    logic [2:0]       len;
    ppmd_pkg::entry_t e;

    phase_next = phase; in_comment_next = in_comment;
    tv_next = tv; tl_next = tl; tb_next = tb; bf_next = bf;
    sw_next = sw; sh_next = sh; ms_next = ms;
    col_next = col; row_next = row; ch_next = ch;
    n = 2'd0; fin = 1'b0; samp = 1'b0; sv = data_byte;
    v = '0; bad = 1'b0; len = '0;
    e = '0;
    ents[0] = '0; ents[1] = '0;

    if (phase == PH_FINISHED) begin
      fin = 1'b0;
    end else if (phase == PH_P6DATA) begin
      samp = 1'b1;
    end else if (in_comment) begin
      if (data_byte == ppmd_pkg::CH_LF) in_comment_next = 1'b0;
    end else if (phase == PH_P6SKIP) begin
      if (data_byte == ppmd_pkg::CH_HASH) begin
        in_comment_next = 1'b1;
      end else if (!ppmd_pkg::is_space(data_byte)) begin
        phase_next = PH_P6DATA;
        samp = 1'b1;
      end
    end else if (ppmd_pkg::is_space(data_byte) || data_byte == ppmd_pkg::CH_HASH) begin
      if (tl != '0) fin = 1'b1;
      if (data_byte == ppmd_pkg::CH_HASH) in_comment_next = 1'b1;
    end else begin
      // token character
      if (phase == PH_MAGIC) begin
        if (tl == 3'd0 && data_byte != ppmd_pkg::CH_P) tb_next = 1'b1;
        if (tl == 3'd1) begin
          if (data_byte == ppmd_pkg::CH_3) bf_next = 1'b0;
          else if (data_byte == ppmd_pkg::CH_6) bf_next = 1'b1;
          else tb_next = 1'b1;
        end
      end else if (data_byte >= ppmd_pkg::CH_0 && data_byte <= ppmd_pkg::CH_9) begin
        tv_next = (acc > (TW+4)'(CAP)) ? CAP : acc[TW-1:0];
      end else begin
        tb_next = 1'b1;
      end
      if (tl != 3'd7) tl_next = tl + 3'd1;
    end

    // token left open by the final byte
    if (end_of_file && phase_next <= PH_P3DATA && tl_next != '0) fin = 1'b1;

    if (fin) begin
      v = tv_next; bad = tb_next; len = tl_next;
      tv_next = '0; tl_next = '0; tb_next = 1'b0;
      e = '0;
      e.etype = ppmd_pkg::ENT_STATUS;
      unique case (phase_next)
        PH_MAGIC: begin
          if (bad || len != 3'd2) begin
            e.status = ppmd_pkg::ST_MAGIC; ents[n[0]] = e; n = n + 2'd1;
            phase_next = PH_FINISHED;
          end else phase_next = PH_WIDTH;
        end
        PH_WIDTH: begin
          if (bad || v == '0 || v[DIM_BITS]) begin
            e.status = ppmd_pkg::ST_HEADER; ents[n[0]] = e; n = n + 2'd1;
            phase_next = PH_FINISHED;
          end else begin
            sw_next = v[DIM_BITS-1:0]; phase_next = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          if (bad || v == '0 || v[DIM_BITS]) begin
            e.status = ppmd_pkg::ST_HEADER; ents[n[0]] = e; n = n + 2'd1;
            phase_next = PH_FINISHED;
          end else begin
            sh_next = v[DIM_BITS-1:0]; phase_next = PH_MAXVAL;
          end
        end
        PH_MAXVAL: begin
          if (bad || v == '0 || v > TW'(ppmd_pkg::SAMPLE_MAX)) begin
            e.status = ppmd_pkg::ST_HEADER; ents[n[0]] = e; n = n + 2'd1;
            phase_next = PH_FINISHED;
          end else begin
            ms_next = v[7:0];
            col_next = '0; row_next = '0; ch_next = '0;
            e.etype = ppmd_pkg::ENT_HEADER;
            e.width = wext[15:0]; e.height = hext[15:0];
            ents[n[0]] = e; n = n + 2'd1;
            phase_next = bf_next ? PH_P6SKIP : PH_P3DATA;
          end
        end
        PH_P3DATA: begin
          if (bad || v > TW'(ms)) begin
            e.status = ppmd_pkg::ST_P3; ents[n[0]] = e; n = n + 2'd1;
            phase_next = PH_FINISHED;
          end else begin
            samp = 1'b1; sv = v[7:0];
          end
        end
        default: fin = 1'b1;
      endcase
    end

    // one colour sample: the scaler keeps red and green until blue comes
    if (samp) begin
      e = '0;
      e.etype = ppmd_pkg::ENT_SAMPLE;
      e.sample = sv; e.chan = ch_next; e.maxv = ms_next;
      ents[n[0]] = e; n = n + 2'd1;
      if (ch_next == 2'd2) begin
        ch_next = '0;
        if (col == sw - 1'b1 && row == sh - 1'b1) begin
          phase_next = PH_FINISHED;
          e = '0;
          e.etype = ppmd_pkg::ENT_STATUS; e.status = ppmd_pkg::ST_OK;
          ents[n[0]] = e; n = n + 2'd1;
        end else if (col == sw - 1'b1) begin
          col_next = '0; row_next = row + 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end else begin
        ch_next = ch_next + 2'd1;
      end
    end

    // short stream and return to reset
    if (end_of_file) begin
      if (phase_next != PH_FINISHED) begin
        e = '0;
        e.etype = ppmd_pkg::ENT_STATUS;
        priority if (phase_next == PH_MAGIC) e.status = ppmd_pkg::ST_MAGIC;
        else if (phase_next <= PH_MAXVAL) e.status = ppmd_pkg::ST_HEADER;
        else if (phase_next == PH_P3DATA) e.status = ppmd_pkg::ST_P3;
        else e.status = ppmd_pkg::ST_P6;
        ents[n[0]] = e; n = n + 2'd1;
      end
      phase_next = PH_MAGIC; in_comment_next = 1'b0;
      tv_next = '0; tl_next = '0; tb_next = 1'b0; bf_next = 1'b0;
      sw_next = '0; sh_next = '0; ms_next = '0;
      col_next = '0; row_next = '0; ch_next = '0;
    end

    if (n == 2'd1) ents[0].last = 1'b1;
    if (n == 2'd2) ents[1].last = 1'b1;
  end

  assign push      = pend_valid ? !q_full : (accept && n != 2'd0);
  assign push_data = pend_valid ? pend : ents[0];

  // state and second-entry holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC; in_comment <= 1'b0;
      tv <= '0; tl <= '0; tb <= 1'b0; bf <= 1'b0;
      sw <= '0; sh <= '0; ms <= '0;
      col <= '0; row <= '0; ch <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !q_full) pend_valid <= 1'b0;
      if (accept) begin
        phase <= phase_next; in_comment <= in_comment_next;
        tv <= tv_next; tl <= tl_next; tb <= tb_next; bf <= bf_next;
        sw <= sw_next; sh <= sh_next; ms <= ms_next;
        col <= col_next; row <= row_next; ch <= ch_next;
        if (n == 2'd2) pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend <= ents[1];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ppmd_back.sv
`default_nettype none
module ppmd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ppmd_pkg::entry_t head,
  input  wire logic             q_empty,
  output logic                  pop,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [1:0]            kind,
  output logic [2:0]            status,
  output logic [15:0]           image_width,
  output logic [15:0]           image_height,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic                  last
);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_t;

  bstate_t    state;
  logic [7:0] rem;
  logic [7:0] lo;
  logic [7:0] divisor;
  logic [2:0] cnt;
  logic [1:0] chan;
  logic       last_r;
  logic [7:0] held_red;
  logic [7:0] held_green;

  logic        direct;
  logic [15:0] numer;
  logic [8:0]  trial;
  logic        ge;
  logic [7:0]  rem_next;
  logic [7:0]  lo_next;
  logic        fin_now;
  logic [7:0]  fin_q;
  logic [1:0]  cur_chan;
  logic        cur_last;

  assign pop          = state == B_IDLE && !q_empty;
  assign result_valid = state == B_OUT;

  // samples at or above maxval scale to full range; else v*255 + m/2
  assign direct = head.sample >= head.maxv;
  assign numer  = {head.sample, 8'b0} - {8'b0, head.sample} + {9'b0, head.maxv[7:1]};

  // one restoring division step
  assign trial    = {rem, lo[7]};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_next = ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
  assign lo_next  = {lo[6:0], ge};

  assign fin_now  = (pop && head.etype == ppmd_pkg::ENT_SAMPLE && direct) ||
                    (state == B_DIV && cnt == 3'd7);
  assign fin_q    = (state == B_IDLE) ? ppmd_pkg::SAMPLE_MAX : lo_next;
  assign cur_chan = (state == B_IDLE) ? head.chan : chan;
  assign cur_last = (state == B_IDLE) ? head.last : last_r;

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            unique case (head.etype)
              ppmd_pkg::ENT_HEADER, ppmd_pkg::ENT_STATUS: state <= B_OUT;
              default: begin
                if (!direct) state <= B_DIV;
                else if (head.chan == 2'd2) state <= B_OUT;
                else state <= B_IDLE;
              end
            endcase
          end
        end
        B_DIV: begin
          if (cnt == 3'd7) state <= (chan == 2'd2) ? B_OUT : B_IDLE;
        end
        default: begin
          if (!result_stall) state <= B_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      chan    <= head.chan;
      last_r  <= head.last;
      divisor <= head.maxv;
      rem     <= numer[15:8];
      lo      <= numer[7:0];
      cnt     <= '0;
      if (head.etype != ppmd_pkg::ENT_SAMPLE) begin
        kind         <= (head.etype == ppmd_pkg::ENT_HEADER) ? ppmd_pkg::KIND_HEADER
                                                             : ppmd_pkg::KIND_STATUS;
        status       <= head.status;
        image_width  <= head.width;
        image_height <= head.height;
        red          <= '0;
        green        <= '0;
        blue         <= '0;
        last         <= head.last;
      end
    end else if (state == B_DIV) begin
      rem <= rem_next;
      lo  <= lo_next;
      cnt <= cnt + 3'd1;
    end
    if (fin_now) begin
      unique case (cur_chan)
        2'd0: held_red   <= fin_q;
        2'd1: held_green <= fin_q;
        default: begin
          kind         <= ppmd_pkg::KIND_PIXEL;
          status       <= ppmd_pkg::ST_OK;
          image_width  <= '0;
          image_height <= '0;
          red          <= held_red;
          green        <= held_green;
          blue         <= fin_q;
          last         <= cur_last;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ppm_stream_decoder_core.sv
`default_nettype none
// PPM stream decoder. Feed the file one byte per beat with end_of_file on its
// final byte; the block returns one header result if the header is valid, one
// pixel result per three samples (scaled to 0..255) and exactly one final
// status result per file. If an error status arrives, drop the pixels already
// taken for that file. The parser stalls bytes while a second result from one
// byte waits for the queue or while the 4-entry queue is full. A sample at or
// above maxval is scaled when taken; other samples go through the 8-step
// restoring divider, and the scaler takes no new entry until it ends. Header
// and status results are registered and held until the receiver takes them.
module ppm_stream_decoder_core #(
  parameter int DIM_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_file,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       kind,
  output logic [2:0]       status,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             last
);

  ppmd_pkg::entry_t push_data;
  ppmd_pkg::entry_t head;
  logic push, pop, q_full, q_empty;

  ppmd_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk, .rst, .byte_valid, .byte_stall, .data_byte, .end_of_file,
    .push, .push_data, .q_full
  );

  ppmd_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .full(q_full), .empty(q_empty)
  );

  ppmd_back u_back (
    .clk, .rst, .head, .q_empty, .pop, .result_valid, .result_stall,
    .kind, .status, .image_width, .image_height, .red, .green, .blue, .last
  );

endmodule
`default_nettype wire

FILE: tb/ppmd_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module ppmd_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  input  wire logic        byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_file,
  input  wire logic        result_valid,
  input  wire logic        result_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [2:0]  status,
  input  wire logic [15:0] image_width,
  input  wire logic [15:0] image_height,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic        last,
  output int               fail_count,
  output int               pending,
  output int               pixels_seen,
  output int               files_seen
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
  } dec_result_t;

  typedef enum logic [3:0] {
    PS_MAGIC, PS_WIDTH, PS_HEIGHT, PS_MAXVAL, PS_P3DATA, PS_P6SKIP, PS_P6DATA, PS_DONE
  } parse_phase_t;

  localparam longint VAL_CAP = 64'd1 << 33;
  localparam longint DIM_LIMIT = 64'd65535;

  dec_result_t  expected_results[$];
  dec_result_t  step_out[$];
  parse_phase_t ph;
  logic         in_cmt;
  longint       tok_val;
  int           tok_len;
  logic         tok_bad;
  logic         is_p6;
  longint       wid, hgt, pix_left;
  int           maxv;
  int           chan;
  logic [7:0]   hold_r, hold_g;

  function automatic logic blank(input logic [7:0] c);
    return c == ppmd_pkg::CH_SP || c == ppmd_pkg::CH_TAB || c == ppmd_pkg::CH_LF ||
           c == ppmd_pkg::CH_VT || c == ppmd_pkg::CH_FF || c == ppmd_pkg::CH_CR;
  endfunction

  function automatic logic [7:0] scaled(input longint v);
    longint s;
    if (maxv == 0) return ppmd_pkg::SAMPLE_MAX;
    s = (v * 255 + maxv / 2) / maxv;
    return (s > 255) ? ppmd_pkg::SAMPLE_MAX : s[7:0];
  endfunction

  task automatic push(input logic [1:0] k, input logic [2:0] st, input longint w,
                      input longint h, input logic [7:0] r, input logic [7:0] g,
                      input logic [7:0] b);
    dec_result_t e;
    e = '{k, st, w[15:0], h[15:0], r, g, b, 1'b0};
    step_out = {step_out, e};
  endtask

  task automatic raise(input logic [2:0] st);
    ph = PS_DONE;
    push(ppmd_pkg::KIND_STATUS, st, 0, 0, 0, 0, 0);
  endtask

  task automatic clear_state();
    ph = PS_MAGIC; in_cmt = 0; tok_val = 0; tok_len = 0; tok_bad = 0; is_p6 = 0;
    wid = 0; hgt = 0; maxv = 0; pix_left = 0; chan = 0; hold_r = 0; hold_g = 0;
  endtask

  task automatic add_sample(input logic [7:0] s);
    if (chan == 0) begin
      hold_r = s; chan = 1;
    end else if (chan == 1) begin
      hold_g = s; chan = 2;
    end else begin
      chan = 0;
      push(ppmd_pkg::KIND_PIXEL, ppmd_pkg::ST_OK, 0, 0, hold_r, hold_g, s);
      if (pix_left > 0) pix_left--;
      if (pix_left == 0) begin
        ph = PS_DONE;
        push(ppmd_pkg::KIND_STATUS, ppmd_pkg::ST_OK, 0, 0, 0, 0, 0);
      end
    end
  endtask

  task automatic close_token();
    longint v;
    logic   bad;
    int     len;
    v = tok_val; bad = tok_bad; len = tok_len;
    tok_val = 0; tok_len = 0; tok_bad = 0;
    case (ph)
      PS_MAGIC: if (bad || len != 2) raise(ppmd_pkg::ST_MAGIC); else ph = PS_WIDTH;
      PS_WIDTH: begin
        if (bad || v == 0 || v > DIM_LIMIT) raise(ppmd_pkg::ST_HEADER);
        else begin wid = v; ph = PS_HEIGHT; end
      end
      PS_HEIGHT: begin
        if (bad || v == 0 || v > DIM_LIMIT) raise(ppmd_pkg::ST_HEADER);
        else begin hgt = v; ph = PS_MAXVAL; end
      end
      PS_MAXVAL: begin
        if (bad || v == 0 || v > 255) raise(ppmd_pkg::ST_HEADER);
        else begin
          maxv = int'(v); pix_left = wid * hgt; chan = 0;
          push(ppmd_pkg::KIND_HEADER, ppmd_pkg::ST_OK, wid, hgt, 0, 0, 0);
          ph = is_p6 ? PS_P6SKIP : PS_P3DATA;
        end
      end
      PS_P3DATA: begin
        if (bad || v > maxv) raise(ppmd_pkg::ST_P3);
        else add_sample(scaled(v));
      end
      default: ;
    endcase
  endtask

  task automatic extend_token(input logic [7:0] c);
    if (ph == PS_MAGIC) begin
      if (tok_len == 0 && c != ppmd_pkg::CH_P) tok_bad = 1;
      if (tok_len == 1) begin
        if (c == ppmd_pkg::CH_3) is_p6 = 0;
        else if (c == ppmd_pkg::CH_6) is_p6 = 1;
        else tok_bad = 1;
      end
    end else if (c >= ppmd_pkg::CH_0 && c <= ppmd_pkg::CH_9) begin
      tok_val = tok_val * 10 + (c - ppmd_pkg::CH_0);
      if (tok_val > VAL_CAP) tok_val = VAL_CAP;
    end else begin
      tok_bad = 1;
    end
    if (tok_len < 7) tok_len++;
  endtask

  // decode one byte into the step buffer, then queue it with last marked
  task automatic decode_byte(input logic [7:0] c, input logic eof);
    dec_result_t e;
    step_out.delete();
    if (ph == PS_DONE) begin
    end else if (ph == PS_P6DATA) begin
      add_sample(scaled(c));
    end else if (in_cmt) begin
      if (c == ppmd_pkg::CH_LF) in_cmt = 0;
    end else if (ph == PS_P6SKIP) begin
      if (c == ppmd_pkg::CH_HASH) in_cmt = 1;
      else if (!blank(c)) begin
        ph = PS_P6DATA;
        add_sample(scaled(c));
      end
    end else if (blank(c) || c == ppmd_pkg::CH_HASH) begin
      if (tok_len > 0) close_token();
      if (c == ppmd_pkg::CH_HASH) in_cmt = 1;
    end else begin
      extend_token(c);
    end
    if (eof) begin
      if (ph <= PS_P3DATA && tok_len > 0) close_token();
      if (ph != PS_DONE) begin
        if (ph == PS_MAGIC) raise(ppmd_pkg::ST_MAGIC);
        else if (ph <= PS_MAXVAL) raise(ppmd_pkg::ST_HEADER);
        else if (ph == PS_P3DATA) raise(ppmd_pkg::ST_P3);
        else raise(ppmd_pkg::ST_P6);
      end
      clear_state();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) begin
      e = step_out[i];
      expected_results = {expected_results, e};
    end
  endtask

  // watch both channels on the rising edge
  always @(posedge clk) begin
    dec_result_t e;
    if (rst) begin
      clear_state();
      expected_results.delete();
      fail_count <= 0;
      pixels_seen <= 0;
      files_seen <= 0;
      pending <= 0;
    end else begin
      if (byte_valid && !byte_stall) decode_byte(data_byte, end_of_file);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat kind=%0d", kind);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (kind == ppmd_pkg::KIND_PIXEL) pixels_seen <= pixels_seen + 1;
          if (kind == ppmd_pkg::KIND_STATUS) files_seen <= files_seen + 1;
          if (kind !== e.kind || status !== e.status || image_width !== e.w ||
              image_height !== e.h || red !== e.r || green !== e.g ||
              blue !== e.b || last !== e.last) begin
            fail_count <= fail_count + 1;
            if (kind !== e.kind) $error("kind exp %0d got %0d", e.kind, kind);
            if (status !== e.status) $error("status exp %0d got %0d", e.status, status);
            if (image_width !== e.w)
              $error("image_width exp %0d got %0d", e.w, image_width);
            if (image_height !== e.h)
              $error("image_height exp %0d got %0d", e.h, image_height);
            if (red !== e.r) $error("red exp %0d got %0d", e.r, red);
            if (green !== e.g) $error("green exp %0d got %0d", e.g, green);
            if (blue !== e.b) $error("blue exp %0d got %0d", e.b, blue);
            if (last !== e.last) $error("last exp %0d got %0d", e.last, last);
          end
        end
      end
      pending <= expected_results.size();
    end
  end
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        byte_valid = 0;
  logic        byte_stall;
  logic [7:0]  data_byte = 0;
  logic        end_of_file = 0;
  logic        result_valid;
  logic        result_stall = 0;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [15:0] image_width, image_height;
  logic [7:0]  red, green, blue;
  logic        last;
  int          fail_count, pending, pixels_seen, files_seen;
  int          idle_cycles = 0;
  int          bytes_sent = 0;
  logic        stim_done = 0;
  logic [7:0]  file_bytes[$];

  always #10 clk = ~clk;

  ppm_stream_decoder_core #(.DIM_BITS(16)) DUT (.*);

  ppmd_checker checker_i (.*);

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !(stim_done && pending == 0)) begin
      $display("watchdog expired");
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall: per result a random stall length is drawn; some stretches have none
  initial begin
    int wait_n;
    int calm;
    calm = 0;
    @(negedge clk);
    forever begin
      if (calm > 0) begin
        calm--;
        wait_n = 0;
      end else begin
        wait_n = $urandom_range(0, 19);
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 60);
      end
      result_stall <= (wait_n > 0);
      repeat (wait_n) @(negedge clk);
      result_stall <= 0;
      do @(negedge clk); while (!(result_valid && !result_stall) && !$isunknown(clk)
                                 && !(result_valid === 1'b1 && result_stall === 1'b0));
    end
  end

  function automatic void add_str(input string s);
    foreach (s[i]) file_bytes = {file_bytes, s[i]};
  endfunction

  function automatic logic [7:0] sep();
    case ($urandom_range(0, 7))
      0: return ppmd_pkg::CH_TAB;
      1: return ppmd_pkg::CH_LF;
      2: return ppmd_pkg::CH_VT;
      3: return ppmd_pkg::CH_FF;
      4: return ppmd_pkg::CH_CR;
      default: return ppmd_pkg::CH_SP;
    endcase
  endfunction

  function automatic void add_sep();
    if ($urandom_range(0, 9) == 0) add_str("# note\n");
    file_bytes = {file_bytes, sep()};
  endfunction

  // file with random content, corrupted or cut short when allow_err is set; small sizes keep the scaler busy briefly
  function automatic void build_file(input logic p6, input int w, input int h,
                                     input int mv, input logic allow_err);
    int n;
    add_str(p6 ? "P6" : "P3"); add_sep();
    add_str($sformatf("%0d", w)); add_sep();
    add_str($sformatf("%0d", h)); add_sep();
    add_str($sformatf("%0d", mv));
    n = w * h * 3;
    if (p6) begin
      file_bytes = {file_bytes, sep()};
      if ($urandom_range(0, 3) == 0) add_str("#c\n");
      for (int i = 0; i < n; i++) file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
    end else begin
      for (int i = 0; i < n; i++) begin
        add_sep();
        add_str($sformatf("%0d", $urandom_range(0, mv)));
      end
    end
    if (allow_err && $urandom_range(0, 2) == 0 && file_bytes.size() > 1)
      file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    if (allow_err && $urandom_range(0, 3) == 0 && file_bytes.size() > 2)
      file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 2)];
    if ($urandom_range(0, 4) == 0) add_str("trailing");
  endfunction

  // sender: one byte per beat, with idle gaps before some bytes; a byte is held while byte_stall is high
  task automatic send_file();
    int gap;
    foreach (file_bytes[i]) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        byte_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      byte_valid <= 1;
      data_byte <= file_bytes[i];
      end_of_file <= (i == file_bytes.size() - 1);
      @(posedge clk);
      while (byte_stall) @(posedge clk);
      bytes_sent++;
      @(negedge clk);
    end
    byte_valid <= 0;
    end_of_file <= 0;
    file_bytes.delete();
  endtask

  initial begin
    int cut;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed files: extremes, both formats, every error kind
    build_file(0, 1, 1, 255, 0); send_file();
    build_file(1, 1, 1, 1, 0); send_file();
    add_str("P3 2 1 3 0 3 4 1 2 3"); send_file();
    add_str("P6 65535 1 255\n"); file_bytes = {file_bytes, 8'hff}; send_file();
    add_str("P7 1 1 1"); send_file();
    add_str("P3 0 1 1"); send_file();
    add_str("P3 1 1 256"); send_file();
    add_str("P3 99999999999 1 1"); send_file();
    add_str("P3 1 1 5#x\n9 1 1"); send_file();
    add_str("P6 1 1 7 #z\n"); file_bytes = {file_bytes, 8'h00}; send_file();
    add_str("P"); send_file();
    add_str("P3 1 1 9 1 a 1"); send_file();
    // random part
    while (bytes_sent < 600) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
      end else if ($urandom_range(0, 19) == 0) begin
        // wide header, only the first few dozen bytes are sent
        build_file(1'($urandom_range(0, 1)), int'($urandom_range(1, 70000)),
                   int'($urandom_range(1, 3)), int'($urandom_range(1, 300)), 0);
        cut = int'($urandom_range(10, 40));
        if (cut > file_bytes.size() - 1) cut = file_bytes.size() - 1;
        file_bytes = file_bytes[0:cut];
      end else begin
        build_file(1'($urandom_range(0, 1)), int'($urandom_range(1, 3)),
                   int'($urandom_range(1, 3)),
                   ($urandom_range(0, 2) == 0) ? 255 : int'($urandom_range(1, 255)), 1);
      end
      send_file();
    end
    stim_done = 1;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d bytes; %0d pixel and %0d status beats checked.",
             bytes_sent, pixels_seen, files_seen);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    @(negedge clk);
  end
endmodule
`default_nettype wire
